>>> rtl/apr_pkg.sv
package apr_pkg;

  // Fixed field widths of the command and result items.
  localparam int unsigned ROW_W = 16;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned CNT_W = 5;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Command codes carried by the cmd field.
  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_ANALYZE = 1'b1
  } cmd_e;

  // Reset value of the node count register.
  localparam cnt_t NODE_COUNT_RESET = 5'd16;

endpackage

>>> rtl/articulation_points_by_removal_core.sv
// Load item: no result. Analyze item over N nodes: 1 + N results, one per pass, the first over
// the whole graph and each later one with one node removed; a pass walks the graph by reads of
// the adjacency memory, and busy stays high until the final pass is reported.
// Each result shows the cycle after its pass ends; busy falls as the final result shows, and
// the next item can be taken in that cycle. Results cannot be stalled. Reset (asynchronous,
// active low) clears the adjacency valid bits, so every row reads as zero; node_count is 16.
module articulation_points_by_removal_core #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Configuration port for node_count.
  input  logic          node_count_we_i,
  input  apr_pkg::cnt_t node_count_i,
  // Command channel.
  input  logic          start,
  output logic          busy,
  input  logic          cmd_i,
  input  apr_pkg::idx_t node_index_i,
  input  apr_pkg::row_t neighbor_row_i,
  // Result channel.
  output logic          result_strobe_o,
  output apr_pkg::idx_t removed_node_o,
  output logic          whole_graph_o,
  output apr_pkg::cnt_t component_count_o,
  output logic          is_cut_o,
  output logic          last_o
);
  import apr_pkg::*;

  localparam int unsigned NODE_LIM = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
  localparam int unsigned AW       = (NODE_LIM > 1) ? $clog2(NODE_LIM) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // Lowest set bit of a mask: {found, index}.
  function automatic logic [IDX_W:0] lowest(input row_t m);
    logic [IDX_W:0] r;
    r = '0;
    for (int k = ROW_W - 1; k >= 0; k--) begin
      if (m[k]) begin
        r = {1'b1, IDX_W'(k)};
      end
    end
    return r;
  endfunction

  state_e        state_q, state_d;
  cnt_t          node_count_q, node_count_d;
  cnt_t          n_q, n_d;
  cnt_t          pass_q, pass_d;
  cnt_t          cnt_q, cnt_d;
  cnt_t          base_q, base_d;
  row_t          seen_q, seen_d;
  row_t          pend_q, pend_d;
  logic          rd_vld_q, rd_vld_d;
  logic [NODE_LIM-1:0] adj_vld_q, adj_vld_d;

  logic          strobe_q, strobe_d;
  idx_t          removed_q, removed_d;
  logic          whole_q, whole_d;
  cnt_t          count_q, count_d;
  logic          cut_q, cut_d;
  logic          last_q, last_d;

  // Adjacency memory and its registered read port.
  row_t          adj_mem [NODE_LIM];
  row_t          rd_data_q;
  logic          rd_hit_q;
  logic          mem_we;
  logic          rd_en;
  idx_t          rd_addr;

  row_t          in_use;
  row_t          fresh;
  logic [IDX_W:0] pick;
  logic [IDX_W:0] start_pick;
  row_t          pick_bit;
  row_t          start_bit;
  cnt_t          n_clamp;

  // Nodes in use, clamped to one up to the node limit.
  always_comb begin
    if (node_count_q == '0) begin
      n_clamp = CNT_W'(1);
    end else if (node_count_q > CNT_W'(NODE_LIM)) begin
      n_clamp = CNT_W'(NODE_LIM);
    end else begin
      n_clamp = node_count_q;
    end
  end

  // Mask of the nodes that take part in the walk.
  always_comb begin
    for (int k = 0; k < ROW_W; k++) begin
      in_use[k] = (CNT_W'(k) < n_q);
    end
  end

  // Newly reached nodes from the row read in the previous cycle.
  assign fresh      = (rd_vld_q && rd_hit_q) ? (rd_data_q & in_use & ~seen_q) : '0;
  assign pick       = lowest(pend_q);
  assign start_pick = lowest(in_use & ~seen_q);
  assign pick_bit   = row_t'(1) << pick[IDX_W-1:0];
  assign start_bit  = row_t'(1) << start_pick[IDX_W-1:0];

  // Sequencer: loads, then walks of the graph, one whole-graph pass and one pass per removed node.
  always_comb begin
    state_d      = state_q;
    node_count_d = node_count_q;
    n_d          = n_q;
    pass_d       = pass_q;
    cnt_d        = cnt_q;
    base_d       = base_q;
    seen_d       = seen_q;
    pend_d       = pend_q;
    rd_vld_d     = 1'b0;
    adj_vld_d    = adj_vld_q;
    strobe_d     = 1'b0;
    removed_d    = removed_q;
    whole_d      = whole_q;
    count_d      = count_q;
    cut_d        = cut_q;
    last_d       = last_q;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;

    if (node_count_we_i) begin
      node_count_d = node_count_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (cmd_i == CMD_ANALYZE) begin
            n_d     = n_clamp;
            pass_d  = '0;
            cnt_d   = '0;
            seen_d  = '0;
            pend_d  = '0;
            state_d = ST_RUN;
          end else if (CNT_W'(node_index_i) < CNT_W'(NODE_LIM)) begin
            mem_we                         = 1'b1;
            adj_vld_d[node_index_i[AW-1:0]] = 1'b1;
          end
        end
      end

      ST_RUN: begin
        seen_d = seen_q | fresh;
        if (pend_q != '0) begin
          // Expand the next pending node while merging what just came back.
          rd_en    = 1'b1;
          rd_addr  = pick[IDX_W-1:0];
          rd_vld_d = 1'b1;
          pend_d   = (pend_q & ~pick_bit) | fresh;
        end else if (fresh != '0) begin
          pend_d = fresh;
        end else if (start_pick[IDX_W]) begin
          // The current walk is over: open a new component.
          cnt_d    = cnt_q + CNT_W'(1);
          seen_d   = seen_q | start_bit;
          rd_en    = 1'b1;
          rd_addr  = start_pick[IDX_W-1:0];
          rd_vld_d = 1'b1;
        end else begin
          // Every node is seen: report this pass.
          strobe_d  = 1'b1;
          whole_d   = (pass_q == '0);
          removed_d = (pass_q == '0) ? '0 : IDX_W'(pass_q - CNT_W'(1));
          count_d   = cnt_q;
          cut_d     = (pass_q != '0) && (cnt_q > base_q);
          last_d    = (pass_q == n_q);
          if (pass_q == '0) begin
            base_d = cnt_q;
          end
          if (pass_q == n_q) begin
            state_d = ST_IDLE;
          end else begin
            pass_d = pass_q + CNT_W'(1);
            cnt_d  = '0;
            seen_d = row_t'(1) << pass_q[IDX_W-1:0];
            pend_d = '0;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= NODE_COUNT_RESET;
      n_q          <= CNT_W'(1);
      pass_q       <= '0;
      cnt_q        <= '0;
      base_q       <= '0;
      seen_q       <= '0;
      pend_q       <= '0;
      rd_vld_q     <= 1'b0;
      adj_vld_q    <= '0;
      strobe_q     <= 1'b0;
      removed_q    <= '0;
      whole_q      <= 1'b0;
      count_q      <= '0;
      cut_q        <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      n_q          <= n_d;
      pass_q       <= pass_d;
      cnt_q        <= cnt_d;
      base_q       <= base_d;
      seen_q       <= seen_d;
      pend_q       <= pend_d;
      rd_vld_q     <= rd_vld_d;
      adj_vld_q    <= adj_vld_d;
      strobe_q     <= strobe_d;
      removed_q    <= removed_d;
      whole_q      <= whole_d;
      count_q      <= count_d;
      cut_q        <= cut_d;
      last_q       <= last_d;
    end
  end

  // Adjacency memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      adj_mem[node_index_i[AW-1:0]] <= neighbor_row_i;
    end
    if (rd_en) begin
      rd_data_q <= adj_mem[rd_addr[AW-1:0]];
      rd_hit_q  <= adj_vld_q[rd_addr[AW-1:0]];
    end
  end

  assign busy              = (state_q == ST_RUN);
  assign result_strobe_o   = strobe_q;
  assign removed_node_o    = removed_q;
  assign whole_graph_o     = whole_q;
  assign component_count_o = count_q;
  assign is_cut_o          = cut_q;
  assign last_o            = last_q;

endmodule

>>> sim/tb_articulation_points_by_removal_core.sv
module tb_articulation_points_by_removal_core;
  timeunit 1ns;
  timeprecision 1ps;

  import apr_pkg::*;

  localparam int unsigned NODE_LIMIT  = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned ITEM_GOAL   = 300;
  localparam int unsigned PRINT_CAP   = 40;

  // One expected result of an analysis run.
  typedef struct packed {
    idx_t removed;
    logic whole;
    cnt_t groups;
    logic cut;
    logic last;
  } tally_t;

  // One row of the directed stimulus table.
  typedef struct {
    bit   is_cfg;
    cnt_t cfg_val;
    cmd_e cmd;
    idx_t idx;
    row_t row;
    bit   typed;
    cnt_t typed_base;
    cnt_t typed_rem;
  } step_t;

  logic clk_i;
  logic rst_ni          = 1'b0;
  logic node_count_we_i = 1'b0;
  cnt_t node_count_i    = '0;
  logic start           = 1'b0;
  logic busy;
  logic cmd_i           = 1'b0;
  idx_t node_index_i    = '0;
  row_t neighbor_row_i  = '0;
  logic result_strobe_o;
  idx_t removed_node_o;
  logic whole_graph_o;
  cnt_t component_count_o;
  logic is_cut_o;
  logic last_o;

  // Mirror of the block's graph and node count.
  row_t graph_rows [NODE_LIMIT];
  cnt_t node_count_q = NODE_COUNT_RESET;

  tally_t pending_q [$];
  step_t  script_q [$];

  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned runs_sent      = 0;
  int unsigned results_seen   = 0;
  int unsigned cuts_seen      = 0;
  int unsigned cfg_writes     = 0;
  int unsigned burst_left     = 0;
  bit          drive_on       = 1'b0;

  articulation_points_by_removal_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .node_count_we_i  (node_count_we_i),
    .node_count_i     (node_count_i),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .node_index_i     (node_index_i),
    .neighbor_row_i   (neighbor_row_i),
    .result_strobe_o  (result_strobe_o),
    .removed_node_o   (removed_node_o),
    .whole_graph_o    (whole_graph_o),
    .component_count_o(component_count_o),
    .is_cut_o         (is_cut_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending.", cycle_count,
               pending_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_CAP) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Number of nodes the walk covers for a given register value.
  function automatic int live_nodes(input cnt_t setting);
    int n;
    n = setting;
    if (n < 1) n = 1;
    if (n > NODE_LIMIT) n = NODE_LIMIT;
    return n;
  endfunction

  // Components among nodes 0..n-1, following stored edges, with one node
  // optionally taken out. A walk marks everything reachable through nodes
  // not yet marked, so its reach is a fixed point of the neighbor rows.
  function automatic int count_groups(input int n, input int dropped);
    logic [NODE_LIMIT:0]   in_use;
    logic [NODE_LIMIT-1:0] marked;
    logic [NODE_LIMIT-1:0] reach;
    logic [NODE_LIMIT-1:0] prior;
    int groups;
    in_use = ({{NODE_LIMIT{1'b0}}, 1'b1} << n) - 1;
    marked = '0;
    groups = 0;
    if (dropped >= 0) marked[dropped] = 1'b1;
    for (int v = 0; v < n; v++) begin
      if (!marked[v]) begin
        groups++;
        reach = '0;
        reach[v] = 1'b1;
        do begin
          prior = reach;
          for (int u = 0; u < n; u++) begin
            if (reach[u]) reach = reach | (graph_rows[u] & in_use[NODE_LIMIT-1:0] & ~marked);
          end
        end while (reach != prior);
        marked = marked | reach;
      end
    end
    return groups;
  endfunction

  // Expected results of one accepted item. Typed rows give the counts
  // directly: the whole-graph count and one count shared by every removal.
  task automatic predict_item(input step_t s);
    tally_t t;
    int n;
    int base;
    int c;
    if (s.cmd == CMD_LOAD) begin
      graph_rows[s.idx] = s.row;
      return;
    end
    n = live_nodes(node_count_q);
    base = s.typed ? int'(s.typed_base) : count_groups(n, -1);
    t = '{removed: '0, whole: 1'b1, groups: cnt_t'(base), cut: 1'b0, last: 1'b0};
    pending_q = {pending_q, t};
    for (int i = 0; i < n; i++) begin
      c = s.typed ? int'(s.typed_rem) : count_groups(n, i);
      t = '{removed: idx_t'(i), whole: 1'b0, groups: cnt_t'(c), cut: c > base,
            last: i == n - 1};
      pending_q = {pending_q, t};
    end
    runs_sent++;
  endtask

  // Present one item and hold it until the block takes it.
  task automatic push_item(input step_t s);
    if (!drive_on) begin
      start <= 1'b1;
      drive_on = 1'b1;
    end
    cmd_i <= s.cmd;
    node_index_i <= s.idx;
    neighbor_row_i <= s.row;
    do @(posedge clk_i); while (busy);
    predict_item(s);
    items_sent++;
  endtask

  // Bursts of back-to-back items, separated by random idle gaps.
  task automatic sender_gap();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    start <= 1'b0;
    drive_on = 1'b0;
    repeat ($urandom_range(1, 15)) @(posedge clk_i);
    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
  endtask

  // Stop sending and let the block drain completely.
  task automatic settle();
    if (drive_on) begin
      start <= 1'b0;
      drive_on = 1'b0;
    end
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_node_count(input cnt_t value);
    node_count_we_i <= 1'b1;
    node_count_i <= value;
    @(posedge clk_i);
    node_count_we_i <= 1'b0;
    node_count_q = value;
    cfg_writes++;
  endtask

  // Table builders for the directed part.
  task automatic add_cfg(input cnt_t value);
    step_t s;
    s = '{is_cfg: 1'b1, cfg_val: value, cmd: CMD_LOAD, idx: '0, row: '0,
          typed: 1'b0, typed_base: '0, typed_rem: '0};
    script_q = {script_q, s};
  endtask

  task automatic add_load(input idx_t idx, input row_t row);
    step_t s;
    s = '{is_cfg: 1'b0, cfg_val: '0, cmd: CMD_LOAD, idx: idx, row: row,
          typed: 1'b0, typed_base: '0, typed_rem: '0};
    script_q = {script_q, s};
  endtask

  task automatic add_run(input bit typed, input cnt_t base, input cnt_t rem);
    step_t s;
    s = '{is_cfg: 1'b0, cfg_val: '0, cmd: CMD_ANALYZE, idx: idx_t'($urandom), row: row_t'($urandom),
          typed: typed, typed_base: base, typed_rem: rem};
    script_q = {script_q, s};
  endtask

  function automatic row_t pick_row();
    case ($urandom_range(0, 4))
      0:       return row_t'($urandom);
      1:       return row_t'($urandom & $urandom & $urandom);
      2:       return '1;
      3:       return '0;
      default: return row_t'(1) << $urandom_range(0, NODE_LIMIT - 1);
    endcase
  endfunction

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk_i) begin : check_results
    tally_t got;
    tally_t want;
    if (rst_ni && result_strobe_o) begin
      got = '{removed: removed_node_o, whole: whole_graph_o, groups: component_count_o,
              cut: is_cut_o, last: last_o};
      if (is_cut_o) cuts_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending (removed %0d, count %0d)",
                                  got.removed, got.groups));
      end else begin
        want = pending_q.pop_front();
        results_seen++;
        if (got.removed !== want.removed)
          report_mismatch($sformatf("removed_node %0d, expected %0d", got.removed, want.removed));
        if (got.whole !== want.whole)
          report_mismatch($sformatf("whole_graph %0b, expected %0b", got.whole, want.whole));
        if (got.groups !== want.groups)
          report_mismatch($sformatf("component_count %0d, expected %0d (removed %0d)",
                                    got.groups, want.groups, want.removed));
        if (got.cut !== want.cut)
          report_mismatch($sformatf("is_cut %0b, expected %0b (removed %0d)",
                                    got.cut, want.cut, want.removed));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b (removed %0d)",
                                    got.last, want.last, want.removed));
      end
    end
  end

  initial begin : stimulus
    step_t s;
    row_t  sym_rows [NODE_LIMIT];
    int    n;
    int    density;
    int    mode;
    int    loads;
    foreach (graph_rows[i]) graph_rows[i] = '0;

    // Directed table: reset state, register extremes, a path graph with two
    // cut vertices, self edges, directed rows and edges to unused nodes.
    add_run(1'b1, 5'd16, 5'd15);
    add_cfg(5'd0);
    add_run(1'b1, 5'd1, 5'd0);
    add_cfg(5'd31);
    add_run(1'b1, 5'd16, 5'd15);
    add_load(4'd0, 16'hFFFF);
    add_load(4'd15, 16'hFFFF);
    add_cfg(5'd2);
    add_run(1'b1, 5'd1, 5'd1);
    add_cfg(5'd16);
    add_run(1'b0, '0, '0);
    add_load(4'd0, 16'h0002);
    add_load(4'd1, 16'h0005);
    add_load(4'd2, 16'h000A);
    add_load(4'd3, 16'h0004);
    add_load(4'd15, 16'h0000);
    add_cfg(5'd4);
    add_run(1'b0, '0, '0);
    add_load(4'd2, 16'h000E);
    add_load(4'd1, 16'h0001);
    add_run(1'b0, '0, '0);
    add_cfg(5'd17);
    add_run(1'b0, '0, '0);
    add_cfg(5'd1);
    add_load(4'd15, 16'hAAAA);
    add_load(4'd7, 16'h5555);
    add_run(1'b0, '0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (script_q[i]) begin
      if (script_q[i].is_cfg) begin
        settle();
        write_node_count(script_q[i].cfg_val);
      end else begin
        push_item(script_q[i]);
        sender_gap();
      end
    end

    // Random phases: a node count, a graph, then one or two analyses.
    while (items_sent < ITEM_GOAL) begin
      settle();
      if ($urandom_range(0, 4) == 0) write_node_count(cnt_t'($urandom_range(0, 31)));
      else write_node_count(cnt_t'($urandom_range(1, 8)));
      n = live_nodes(node_count_q);
      mode = $urandom_range(0, 5);
      s = '{is_cfg: 1'b0, cfg_val: '0, cmd: CMD_LOAD, idx: '0, row: '0,
            typed: 1'b0, typed_base: '0, typed_rem: '0};
      if (mode < 4) begin
        // Undirected graph of random density, sometimes with stray high bits.
        density = $urandom_range(5, 60);
        foreach (sym_rows[i]) sym_rows[i] = '0;
        for (int i = 0; i < n; i++) begin
          for (int j = i + 1; j < n; j++) begin
            if ($urandom_range(0, 99) < density) begin
              sym_rows[i][j] = 1'b1;
              sym_rows[j][i] = 1'b1;
            end
          end
        end
        for (int i = 0; i < n; i++) begin
          s.idx = idx_t'(i);
          s.row = sym_rows[i];
          if ($urandom_range(0, 5) == 0) s.row = s.row | (row_t'($urandom) << n);
          if ($urandom_range(0, 9) == 0) s.row[i] = 1'b1;
          push_item(s);
          sender_gap();
        end
      end else begin
        // Scattered directed rows over any index.
        loads = $urandom_range(1, 5);
        for (int i = 0; i < loads; i++) begin
          s.idx = idx_t'($urandom_range(0, NODE_LIMIT - 1));
          s.row = pick_row();
          push_item(s);
          sender_gap();
        end
      end
      repeat ($urandom_range(1, 2)) begin
        s.cmd = CMD_ANALYZE;
        s.idx = idx_t'($urandom);
        s.row = row_t'($urandom);
        push_item(s);
        sender_gap();
      end
    end

    settle();
    repeat (50) @(posedge clk_i);
    if (pending_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_q.size()));

    $display("Sent %0d items including %0d analyses over %0d node-count settings.",
             items_sent, runs_sent, cfg_writes);
    $display("Checked %0d results, %0d of them flagged as cut vertices; %0d mismatches.",
             results_seen, cuts_seen, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/apr_pkg.sv
rtl/articulation_points_by_removal_core.sv
sim/tb_articulation_points_by_removal_core.sv
